/* sv/lim_pkg.sv */
// Shared types, constants and the CORDIC arctangent table for the lock-in impedance meter.
package lim_pkg;

    localparam int CORDIC_STEPS = 30;
    localparam int STEP_W       = 5;
    localparam int ANG_W        = 34;
    localparam int CRD_W        = 33;
    localparam int T_W          = 64;
    localparam int SHUNT_W      = 22;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 32;
    localparam int Z_W          = 48;
    localparam int PH_W         = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SHUNT_OHMS = 2'd1;

    localparam logic [SHUNT_W-1:0] SHUNT_RESET = 22'd300;
    localparam logic signed [CRD_W-1:0] INV_GAIN_Q30 = 33'sd652032874;

    // one finished window: doubled trapezoid sums with guard bits, plus the shunt
    typedef struct packed {
        logic signed [T_W-1:0] t_us;
        logic signed [T_W-1:0] t_uc;
        logic signed [T_W-1:0] t_is;
        logic signed [T_W-1:0] t_ic;
        logic [SHUNT_W-1:0]    shunt;
    } lim_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } lim_q_stat_t;

    // arctangent of 2^-k in 2^-32 turn
    function automatic logic [31:0] atan_turn(input logic [STEP_W-1:0] k);
        logic [31:0] v;
        begin
            v = 32'd0;
            case (k)
                5'd0:  v = 32'd536870912;
                5'd1:  v = 32'd316933406;
                5'd2:  v = 32'd167458907;
                5'd3:  v = 32'd85004756;
                5'd4:  v = 32'd42667331;
                5'd5:  v = 32'd21354465;
                5'd6:  v = 32'd10679838;
                5'd7:  v = 32'd5340245;
                5'd8:  v = 32'd2670163;
                5'd9:  v = 32'd1335087;
                5'd10: v = 32'd667544;
                5'd11: v = 32'd333772;
                5'd12: v = 32'd166886;
                5'd13: v = 32'd83443;
                5'd14: v = 32'd41722;
                5'd15: v = 32'd20861;
                5'd16: v = 32'd10430;
                5'd17: v = 32'd5215;
                5'd18: v = 32'd2608;
                5'd19: v = 32'd1304;
                5'd20: v = 32'd652;
                5'd21: v = 32'd326;
                5'd22: v = 32'd163;
                5'd23: v = 32'd81;
                5'd24: v = 32'd41;
                5'd25: v = 32'd20;
                5'd26: v = 32'd10;
                5'd27: v = 32'd5;
                5'd28: v = 32'd3;
                5'd29: v = 32'd1;
                default: v = 32'd0;
            endcase
            return v;
        end
    endfunction

endpackage

/* sv/lock_in_impedance_meter.sv */
// Top level of the lock-in impedance meter: register file, front end, window queue, back end.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+---------------------------------------------
//  sample   | start / busy          | volt_source, volt_shunt, last_sample
//  result   | result_valid (strobe) | z_real, z_imag, phase_deg, zero_current
//  config   | cfg_valid / cfg_ready | cfg_index, cfg_data
//
//  A sample runs the 30-step rotation CORDIC of the reference oscillator; a last
//  sample also forms and queues the window, and holds busy for longer while the
//  queue is full.
//  Per window the back end runs two 30-step vectoring passes, a 102-step divider,
//  one rotation and projection; two windows can wait in the queue.
//  Reset clears control state and the registers (phase_step 0, shunt_ohms 300).
//  Results are one-cycle strobes; the receiver cannot stall them.
module lock_in_impedance_meter #(
    parameter int SAMPLE_BITS = 14,
    parameter int SINE_BITS   = 16,
    parameter int PHASE_BITS  = 32,
    parameter int WINDOW_LOG2 = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic signed [SAMPLE_BITS-1:0]         volt_source,
    input  logic signed [SAMPLE_BITS-1:0]         volt_shunt,
    input  logic                                  last_sample,
    output logic                                  result_valid,
    output logic signed [lim_pkg::Z_W-1:0]        z_real,
    output logic signed [lim_pkg::Z_W-1:0]        z_imag,
    output logic signed [lim_pkg::PH_W-1:0]       phase_deg,
    output logic                                  zero_current,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [lim_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [lim_pkg::CFG_DATA_W-1:0]        cfg_data
);

    logic [31:0]                 phase_step_reg;
    logic [lim_pkg::SHUNT_W-1:0] shunt_ohms_reg;

    logic                 push;
    logic                 pop;
    lim_pkg::lim_entry_t  push_entry;
    lim_pkg::lim_entry_t  pop_entry;
    lim_pkg::lim_q_stat_t q_stat;

    assign cfg_ready = 1'b1;

    // register writes; other indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_step_reg <= '0;
            shunt_ohms_reg <= lim_pkg::SHUNT_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                lim_pkg::CFG_PHASE_STEP: phase_step_reg <= cfg_data;
                lim_pkg::CFG_SHUNT_OHMS: shunt_ohms_reg <= cfg_data[lim_pkg::SHUNT_W-1:0];
                default: ;
            endcase
        end
    end

    lim_front #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .SINE_BITS   (SINE_BITS),
        .PHASE_BITS  (PHASE_BITS),
        .WINDOW_LOG2 (WINDOW_LOG2)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .volt_source (volt_source),
        .volt_shunt  (volt_shunt),
        .last_sample (last_sample),
        .phase_step  (phase_step_reg),
        .shunt_ohms  (shunt_ohms_reg),
        .q_stat      (q_stat),
        .push        (push),
        .push_entry  (push_entry)
    );

    lim_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .pop_entry  (pop_entry),
        .stat       (q_stat)
    );

    lim_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_stat       (q_stat),
        .pop          (pop),
        .entry        (pop_entry),
        .result_valid (result_valid),
        .z_real       (z_real),
        .z_imag       (z_imag),
        .phase_deg    (phase_deg),
        .zero_current (zero_current)
    );

endmodule

/* sv/lim_rotate.sv */
// Iterative rotation CORDIC: cosine and sine of an angle in 2^-32 turn, one step per cycle.
module lim_rotate (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic signed [lim_pkg::ANG_W-1:0]  ang,
    output logic                              done,
    output logic signed [lim_pkg::CRD_W-1:0]  cos_out,
    output logic signed [lim_pkg::CRD_W-1:0]  sin_out
);

    localparam logic signed [lim_pkg::ANG_W-1:0] QUARTER = 34'sd1073741824;
    localparam logic signed [lim_pkg::ANG_W-1:0] HALF    = 34'sd2147483648;

    logic                             run_reg;
    logic                             done_reg;
    logic [lim_pkg::STEP_W-1:0]       k_reg;
    logic signed [lim_pkg::CRD_W-1:0] x_reg;
    logic signed [lim_pkg::CRD_W-1:0] y_reg;
    logic signed [lim_pkg::ANG_W-1:0] z_reg;
    logic                             neg_reg;

    logic signed [lim_pkg::CRD_W-1:0] xk;
    logic signed [lim_pkg::CRD_W-1:0] yk;
    logic signed [lim_pkg::ANG_W-1:0] atn;

    assign xk  = x_reg >>> k_reg;
    assign yk  = y_reg >>> k_reg;
    assign atn = $signed(lim_pkg::ANG_W'(lim_pkg::atan_turn(k_reg)));

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            k_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                k_reg   <= '0;
            end
            else if (run_reg)
            begin
                k_reg <= k_reg + 1'b1;
                if (k_reg == lim_pkg::STEP_W'(lim_pkg::CORDIC_STEPS - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath: fold into +-90 degrees, then micro-rotations
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg <= lim_pkg::INV_GAIN_Q30;
            y_reg <= '0;
            if (ang > QUARTER)
            begin
                z_reg   <= ang - HALF;
                neg_reg <= 1'b1;
            end
            else if (ang < -QUARTER)
            begin
                z_reg   <= ang + HALF;
                neg_reg <= 1'b1;
            end
            else
            begin
                z_reg   <= ang;
                neg_reg <= 1'b0;
            end
        end
        else if (run_reg)
        begin
            if (z_reg >= 0)
            begin
                x_reg <= x_reg - yk;
                y_reg <= y_reg + xk;
                z_reg <= z_reg - atn;
            end
            else
            begin
                x_reg <= x_reg + yk;
                y_reg <= y_reg - xk;
                z_reg <= z_reg + atn;
            end
        end
    end

    assign done    = done_reg;
    assign cos_out = neg_reg ? -x_reg : x_reg;
    assign sin_out = neg_reg ? -y_reg : y_reg;

endmodule

/* sv/lim_front.sv */
// Front end: reference oscillator, sample products and window sums; hands finished windows on.
module lim_front #(
    parameter int SAMPLE_BITS = 14,
    parameter int SINE_BITS   = 16,
    parameter int PHASE_BITS  = 32,
    parameter int WINDOW_LOG2 = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic signed [SAMPLE_BITS-1:0]     volt_source,
    input  logic signed [SAMPLE_BITS-1:0]     volt_shunt,
    input  logic                              last_sample,
    input  logic [31:0]                       phase_step,
    input  logic [lim_pkg::SHUNT_W-1:0]       shunt_ohms,
    input  lim_pkg::lim_q_stat_t              q_stat,
    output logic                              push,
    output lim_pkg::lim_entry_t               push_entry
);

    localparam int U_W   = SAMPLE_BITS + 1;
    localparam int P_W   = SAMPLE_BITS + SINE_BITS + 1;
    localparam int SUM_W = SAMPLE_BITS + SINE_BITS + WINDOW_LOG2 + 2;
    localparam int GUARD = 59 - SUM_W;
    localparam int MW    = lim_pkg::CRD_W + SINE_BITS + 1;
    localparam logic signed [SINE_BITS:0] AMP =
        (SINE_BITS + 1)'((64'd1 << (SINE_BITS - 1)) - 64'd1);
    localparam logic signed [SUM_W:0] SLIM =
        (SUM_W + 1)'((64'd1 << (SUM_W - 1)) - 64'd1);

    typedef enum logic [2:0] {
        F_IDLE, F_ROT, F_SCALE, F_PROD, F_ACC, F_TRAP, F_PUSH
    } f_state_t;

    f_state_t                    state_reg;
    logic [PHASE_BITS-1:0]       ref_phase_reg;
    logic                        started_reg;
    logic                        last_reg;

    logic signed [U_W-1:0]       u_reg;
    logic signed [U_W-1:0]       i_reg;
    logic signed [SINE_BITS-1:0] sn_reg;
    logic signed [SINE_BITS-1:0] cs_reg;
    logic signed [P_W-1:0]       p_reg     [4];
    logic signed [SUM_W-1:0]     sum_reg   [4];
    logic signed [P_W-1:0]       first_reg [4];
    logic signed [P_W-1:0]       prev_reg  [4];
    lim_pkg::lim_entry_t         entry_reg;

    logic                              accept;
    logic [31:0]                       a32;
    logic signed [lim_pkg::ANG_W-1:0]  rot_ang;
    logic                              rot_done;
    logic signed [lim_pkg::CRD_W-1:0]  rot_c;
    logic signed [lim_pkg::CRD_W-1:0]  rot_s;
    logic signed [MW-1:0]              sc_s;
    logic signed [MW-1:0]              sc_c;
    logic signed [SINE_BITS-1:0]       sn_next;
    logic signed [SINE_BITS-1:0]       cs_next;
    logic signed [SUM_W:0]             acc_next [4];
    logic signed [lim_pkg::T_W-1:0]    t_next   [4];

    assign accept  = start && (state_reg == F_IDLE);
    assign busy    = (state_reg != F_IDLE);
    assign a32     = 32'(ref_phase_reg) << (32 - PHASE_BITS);
    assign rot_ang = lim_pkg::ANG_W'($signed(a32));

    lim_rotate u_rot (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (accept),
        .ang     (rot_ang),
        .done    (rot_done),
        .cos_out (rot_c),
        .sin_out (rot_s)
    );

    // reference amplitude scaling with rounding and clamp
    always_comb
    begin
        sc_s = ((MW'(rot_s) * MW'(AMP)) + MW'(64'sd536870912)) >>> 30;
        sc_c = ((MW'(rot_c) * MW'(AMP)) + MW'(64'sd536870912)) >>> 30;
        if (sc_s > MW'(AMP))
            sn_next = SINE_BITS'(AMP);
        else if (sc_s < -MW'(AMP))
            sn_next = SINE_BITS'(-AMP);
        else
            sn_next = SINE_BITS'(sc_s);
        if (sc_c > MW'(AMP))
            cs_next = SINE_BITS'(AMP);
        else if (sc_c < -MW'(AMP))
            cs_next = SINE_BITS'(-AMP);
        else
            cs_next = SINE_BITS'(sc_c);
    end

    // saturating sums and doubled trapezoids
    always_comb
    begin
        for (int n = 0; n < 4; n++)
        begin
            acc_next[n] = (SUM_W + 1)'(sum_reg[n]) + (SUM_W + 1)'(p_reg[n]);
            if (acc_next[n] > SLIM)
                acc_next[n] = SLIM;
            else if (acc_next[n] < -SLIM)
                acc_next[n] = -SLIM;
            t_next[n] = ((lim_pkg::T_W'(sum_reg[n]) <<< 1) - lim_pkg::T_W'(first_reg[n])
                         - lim_pkg::T_W'(prev_reg[n])) <<< GUARD;
        end
    end

    // sequencer and window state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= F_IDLE;
            ref_phase_reg <= '0;
            started_reg   <= 1'b0;
            push          <= 1'b0;
        end
        else
        begin
            push <= 1'b0;
            unique case (state_reg)
                F_IDLE:
                begin
                    if (accept)
                    begin
                        ref_phase_reg <= ref_phase_reg + phase_step[PHASE_BITS-1:0];
                        state_reg     <= F_ROT;
                    end
                end
                F_ROT:
                begin
                    if (rot_done)
                        state_reg <= F_SCALE;
                end
                F_SCALE: state_reg <= F_PROD;
                F_PROD:  state_reg <= F_ACC;
                F_ACC:
                begin
                    started_reg <= 1'b1;
                    state_reg   <= last_reg ? F_TRAP : F_IDLE;
                end
                F_TRAP:
                begin
                    started_reg   <= 1'b0;
                    ref_phase_reg <= '0;
                    state_reg     <= F_PUSH;
                end
                F_PUSH:
                begin
                    if (!q_stat.full)
                    begin
                        push      <= 1'b1;
                        state_reg <= F_IDLE;
                    end
                end
                default: state_reg <= F_IDLE;
            endcase
        end
    end

    // sample datapath
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            u_reg    <= U_W'(volt_source) - U_W'(volt_shunt);
            i_reg    <= U_W'(volt_shunt);
            last_reg <= last_sample;
        end
        if (state_reg == F_SCALE)
        begin
            sn_reg <= sn_next;
            cs_reg <= cs_next;
        end
        if (state_reg == F_PROD)
        begin
            p_reg[0] <= P_W'(u_reg) * P_W'(sn_reg);
            p_reg[1] <= P_W'(u_reg) * P_W'(cs_reg);
            p_reg[2] <= P_W'(i_reg) * P_W'(sn_reg);
            p_reg[3] <= P_W'(i_reg) * P_W'(cs_reg);
        end
        if (state_reg == F_ACC)
        begin
            for (int n = 0; n < 4; n++)
            begin
                if (!started_reg)
                begin
                    sum_reg[n]   <= SUM_W'(p_reg[n]);
                    first_reg[n] <= p_reg[n];
                end
                else
                    sum_reg[n] <= SUM_W'(acc_next[n]);
                prev_reg[n] <= p_reg[n];
            end
        end
        if (state_reg == F_TRAP)
        begin
            entry_reg.t_us  <= t_next[0];
            entry_reg.t_uc  <= t_next[1];
            entry_reg.t_is  <= t_next[2];
            entry_reg.t_ic  <= t_next[3];
            entry_reg.shunt <= shunt_ohms;
            for (int n = 0; n < 4; n++)
                sum_reg[n] <= '0;
        end
    end

    assign push_entry = entry_reg;

endmodule

/* sv/lim_queue.sv */
// Two-entry queue of finished windows between the front and back ends.
module lim_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  lim_pkg::lim_entry_t  push_entry,
    input  logic                 pop,
    output lim_pkg::lim_entry_t  pop_entry,
    output lim_pkg::lim_q_stat_t stat
);

    lim_pkg::lim_entry_t slot_reg [2];
    logic                wr_ptr_reg;
    logic                rd_ptr_reg;
    logic [1:0]          count_reg;

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_entry;
    end

    assign pop_entry  = slot_reg[rd_ptr_reg];
    assign stat.full  = (count_reg == 2'd2);
    assign stat.empty = (count_reg == 2'd0);

endmodule

/* sv/lim_back.sv */
// Back end: vectoring CORDIC, magnitude ratio divider, phase rotation and projection.
module lim_back (
    input  logic                                clk,
    input  logic                                rst_n,
    input  lim_pkg::lim_q_stat_t                q_stat,
    output logic                                pop,
    input  lim_pkg::lim_entry_t                 entry,
    output logic                                result_valid,
    output logic signed [lim_pkg::Z_W-1:0]      z_real,
    output logic signed [lim_pkg::Z_W-1:0]      z_imag,
    output logic signed [lim_pkg::PH_W-1:0]     phase_deg,
    output logic                                zero_current
);

    localparam int T_W   = lim_pkg::T_W;
    localparam int PR_W  = 86;
    localparam int DV_W  = 102;
    localparam int Q_W   = 61;
    localparam int CNT_W = 7;
    localparam int PHM_W = 52;
    localparam logic signed [T_W-1:0] Z_MAX = 64'sd140737488355327;
    localparam logic signed [T_W-1:0] Z_MIN = -64'sd140737488355328;

    typedef enum logic [3:0] {
        B_IDLE, B_VEC, B_CHECK, B_MUL_LO, B_MUL_HI, B_DIV, B_ROT,
        B_PRJ_MUL, B_PRJ_FIN, B_OUT
    } b_state_t;

    b_state_t                     state_reg;
    logic                         pass_reg;
    logic                         sel_reg;
    logic [lim_pkg::STEP_W-1:0]   k_reg;
    logic [CNT_W-1:0]             cnt_reg;
    logic                         valid_reg;
    logic                         zc_reg;

    lim_pkg::lim_entry_t              ent_reg;
    logic signed [T_W-1:0]            x_reg;
    logic signed [T_W-1:0]            y_reg;
    logic [31:0]                      z_reg;
    logic [T_W-1:0]                   mu_reg;
    logic [T_W-1:0]                   mi_reg;
    logic [31:0]                      au_reg;
    logic signed [lim_pkg::ANG_W-1:0] d_reg;
    logic [53:0]                      plo_reg;
    logic [DV_W-1:0]                  dvd_reg;
    logic [T_W-1:0]                   rem_reg;
    logic [Q_W-1:0]                   q_reg;
    logic                             sat_reg;
    logic signed [T_W-1:0]            hi_reg;
    logic signed [T_W-1:0]            lo_reg;
    logic signed [lim_pkg::Z_W-1:0]   zr_reg;
    logic signed [lim_pkg::Z_W-1:0]   zi_reg;
    logic signed [lim_pkg::PH_W-1:0]  ph_reg;

    logic signed [T_W-1:0]            xk;
    logic signed [T_W-1:0]            yk;
    logic [31:0]                      atn;
    logic signed [T_W-1:0]            x_step;
    logic signed [T_W-1:0]            y_step;
    logic [31:0]                      z_step;
    logic signed [T_W-1:0]            vx0;
    logic signed [T_W-1:0]            vy0;
    logic [31:0]                      vz0;
    logic [31:0]                      diff;
    logic [T_W:0]                     rem_sh;
    logic                             ge;
    logic                             rot_start;
    logic                             rot_done;
    logic signed [lim_pkg::CRD_W-1:0] rot_c;
    logic signed [lim_pkg::CRD_W-1:0] rot_s;
    logic signed [lim_pkg::CRD_W-1:0] opnd;
    logic signed [T_W-1:0]            z_fin;
    logic signed [T_W-1:0]            lo_rnd;
    logic signed [PHM_W-1:0]          ph_full;

    // vectoring micro-rotation
    always_comb
    begin
        xk  = x_reg >>> k_reg;
        yk  = y_reg >>> k_reg;
        atn = lim_pkg::atan_turn(k_reg);
        if (y_reg > 0)
        begin
            x_step = x_reg + yk;
            y_step = y_reg - xk;
            z_step = z_reg + atn;
        end
        else
        begin
            x_step = x_reg - yk;
            y_step = y_reg + xk;
            z_step = z_reg - atn;
        end
    end

    // vectoring start: move the vector into the right half plane
    always_comb
    begin
        if (pass_reg == 1'b0 && state_reg == B_IDLE)
        begin
            vx0 = entry.t_us;
            vy0 = entry.t_uc;
        end
        else
        begin
            vx0 = ent_reg.t_is;
            vy0 = ent_reg.t_ic;
        end
        vz0 = 32'd0;
        if (vx0 < 0)
        begin
            vx0 = -vx0;
            vy0 = -vy0;
            vz0 = 32'h8000_0000;
        end
    end

    assign diff   = au_reg - z_reg;
    assign rem_sh = {rem_reg, dvd_reg[DV_W-1]};
    assign ge     = (rem_sh >= {1'b0, mi_reg});
    assign pop    = (state_reg == B_IDLE) && !q_stat.empty;
    assign rot_start = (state_reg == B_DIV) && (cnt_reg == '0);

    lim_rotate u_rot (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (rot_start),
        .ang     (d_reg),
        .done    (rot_done),
        .cos_out (rot_c),
        .sin_out (rot_s)
    );

    // projection of the ratio onto cosine or sine
    always_comb
    begin
        opnd   = sel_reg ? rot_s : rot_c;
        lo_rnd = (lo_reg + 64'sd536870912) >>> 30;
        if (hi_reg > Z_MAX + 64'sd1 || hi_reg < Z_MIN - 64'sd1)
            z_fin = (hi_reg > 0) ? Z_MAX : Z_MIN;
        else
        begin
            z_fin = hi_reg + lo_rnd;
            if (z_fin > Z_MAX)
                z_fin = Z_MAX;
            else if (z_fin < Z_MIN)
                z_fin = Z_MIN;
        end
        ph_full = (PHM_W'(d_reg) * 52'sd23040 + 52'sd1073741824) >>> 31;
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            pass_reg  <= 1'b0;
            sel_reg   <= 1'b0;
            k_reg     <= '0;
            cnt_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= 1'b0;
            unique case (state_reg)
                B_IDLE:
                begin
                    if (!q_stat.empty)
                    begin
                        pass_reg  <= 1'b0;
                        k_reg     <= '0;
                        state_reg <= B_VEC;
                    end
                end
                B_VEC:
                begin
                    if (k_reg == lim_pkg::STEP_W'(lim_pkg::CORDIC_STEPS - 1))
                    begin
                        k_reg <= '0;
                        if (pass_reg == 1'b0)
                            pass_reg <= 1'b1;
                        else
                            state_reg <= B_CHECK;
                    end
                    else
                        k_reg <= k_reg + 1'b1;
                end
                B_CHECK:
                begin
                    pass_reg  <= 1'b0;
                    state_reg <= (mi_reg == '0) ? B_OUT : B_MUL_LO;
                end
                B_MUL_LO: state_reg <= B_MUL_HI;
                B_MUL_HI:
                begin
                    cnt_reg   <= CNT_W'(DV_W - 1);
                    state_reg <= B_DIV;
                end
                B_DIV:
                begin
                    if (cnt_reg == '0)
                        state_reg <= B_ROT;
                    else
                        cnt_reg <= cnt_reg - 1'b1;
                end
                B_ROT:
                begin
                    if (rot_done)
                    begin
                        sel_reg   <= 1'b0;
                        state_reg <= B_PRJ_MUL;
                    end
                end
                B_PRJ_MUL: state_reg <= B_PRJ_FIN;
                B_PRJ_FIN:
                begin
                    if (sel_reg == 1'b0)
                    begin
                        sel_reg   <= 1'b1;
                        state_reg <= B_PRJ_MUL;
                    end
                    else
                        state_reg <= B_OUT;
                end
                B_OUT:
                begin
                    valid_reg <= 1'b1;
                    state_reg <= B_IDLE;
                end
                default: state_reg <= B_IDLE;
            endcase
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            B_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    ent_reg <= entry;
                    x_reg   <= vx0;
                    y_reg   <= vy0;
                    z_reg   <= vz0;
                end
            end
            B_VEC:
            begin
                if (k_reg == lim_pkg::STEP_W'(lim_pkg::CORDIC_STEPS - 1) && pass_reg == 1'b0)
                begin
                    mu_reg <= x_step;
                    au_reg <= z_step;
                    x_reg  <= vx0;
                    y_reg  <= vy0;
                    z_reg  <= vz0;
                end
                else
                begin
                    x_reg <= x_step;
                    y_reg <= y_step;
                    z_reg <= z_step;
                    if (k_reg == lim_pkg::STEP_W'(lim_pkg::CORDIC_STEPS - 1))
                        mi_reg <= x_step;
                end
            end
            B_CHECK:
            begin
                if (mi_reg == '0)
                begin
                    zr_reg <= lim_pkg::Z_W'(Z_MAX);
                    zi_reg <= '0;
                    ph_reg <= '0;
                    zc_reg <= 1'b1;
                end
                else
                begin
                    zc_reg <= 1'b0;
                    // minus 180 degrees reads as plus 180
                    if (diff == 32'h8000_0000)
                        d_reg <= 34'sd2147483648;
                    else
                        d_reg <= lim_pkg::ANG_W'($signed(diff));
                end
            end
            B_MUL_LO:
            begin
                plo_reg <= 54'(mu_reg[31:0]) * 54'(ent_reg.shunt);
                ph_reg  <= lim_pkg::PH_W'(ph_full);
            end
            B_MUL_HI:
            begin
                dvd_reg <= DV_W'(((PR_W'(mu_reg[63:32]) * PR_W'(ent_reg.shunt)) << 32)
                                 + PR_W'(plo_reg)) << 16;
                rem_reg <= '0;
                q_reg   <= '0;
                sat_reg <= 1'b0;
            end
            B_DIV:
            begin
                dvd_reg <= dvd_reg << 1;
                rem_reg <= ge ? T_W'(rem_sh - {1'b0, mi_reg}) : T_W'(rem_sh);
                if (cnt_reg >= CNT_W'(Q_W))
                begin
                    if (ge)
                        sat_reg <= 1'b1;
                end
                else
                    q_reg <= {q_reg[Q_W-2:0], ge};
            end
            B_ROT:
            begin
                if (rot_done && sat_reg)
                    q_reg <= '1;
            end
            B_PRJ_MUL:
            begin
                hi_reg <= T_W'($signed({2'b00, q_reg[Q_W-1:30]}) * opnd);
                lo_reg <= T_W'($signed({2'b00, q_reg[29:0]}) * opnd);
            end
            B_PRJ_FIN:
            begin
                if (sel_reg == 1'b0)
                    zr_reg <= lim_pkg::Z_W'(z_fin);
                else
                    zi_reg <= lim_pkg::Z_W'(z_fin);
            end
            B_OUT: ;
            default: ;
        endcase
    end

    assign result_valid = valid_reg;
    assign z_real       = zr_reg;
    assign z_imag       = zi_reg;
    assign phase_deg    = ph_reg;
    assign zero_current = zc_reg;

endmodule
